>>> rtl/lpbt_pkg.sv
package lpbt_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int OP_W        = 2;
  localparam int TID_W       = 6;
  localparam int PAGE_W      = 32;
  localparam int SLOT_PORT_W = 4;

  localparam logic [OP_W-1:0] OP_READ    = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [SLOT_W:0]   slot_cnt_t;

  typedef struct packed {
    logic      valid;
    logic      dirty;
    logic      pinned;
    slot_idx_t rank;
  } slot_flags_t;

  typedef struct packed {
    logic      en;
    slot_idx_t idx;
    logic      promote;
    slot_idx_t old_rank;
    logic      fill;
    logic      dirty_set;
    logic      pin_we;
    logic      pin_val;
  } slot_cmd_t;

endpackage

>>> rtl/lru_page_buffer_tags.sv
// Completion: done is registered in the update state, and busy is low again in the
// same cycle in which done is high.
// A new transaction is accepted only while idle; each one takes one tag compare per slot
// through the single tag RAM read port, plus a victim tag read and an update state.
// Reset (rst, synchronous): all slots invalid, clean and unpinned, rank = slot index.
// Results cannot be stalled: each is presented for one cycle with done.
module lru_page_buffer_tags
  import lpbt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_W-1:0]        opcode,
  input  logic [TID_W-1:0]       file_id,
  input  logic [PAGE_W-1:0]      page_no,
  input  logic                   pin,
  output logic                   done,
  output logic                   hit,
  output logic [SLOT_PORT_W-1:0] slot,
  output logic                   slot_used,
  output logic                   fetch_needed,
  output logic                   writeback_needed,
  output logic [TID_W-1:0]       writeback_table,
  output logic [PAGE_W-1:0]      writeback_page
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_VICT = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]        state;
  logic [OP_W-1:0]   op_r;
  logic [TID_W-1:0]  tid_r;
  logic [PAGE_W-1:0] pn_r;
  logic              pin_r;
  slot_cnt_t         cnt;
  logic              cmp_vld;
  slot_idx_t         cmp_idx;
  logic              found;
  slot_idx_t         found_idx;
  slot_idx_t         found_rank;
  logic              vic_ok;
  slot_idx_t         vic_idx;
  slot_idx_t         vic_rank;
  logic              vic_valid;
  logic              vic_dirty;

  logic              ram_re;
  slot_idx_t         ram_raddr;
  logic [TID_W-1:0]  rd_table;
  logic [PAGE_W-1:0] rd_page;
  logic              tag_we;
  slot_flags_t       flags;
  slot_cmd_t         cmd;

  logic              hit_next;
  slot_idx_t         slot_next;
  logic              used_next;
  logic              fetch_next;
  logic              wb_next;
  logic [SLOT_W+SLOT_PORT_W-1:0] slot_wide;

  assign busy      = (state != ST_IDLE);
  assign ram_re    = ((state == ST_SCAN) && !cnt[SLOT_W]) || (state == ST_VICT);
  assign ram_raddr = (state == ST_VICT) ? vic_idx : cnt[SLOT_W-1:0];

  lpbt_tag_ram u_tag_ram (
    .clk    (clk),
    .we     (tag_we),
    .waddr  (vic_idx),
    .wtable (tid_r),
    .wpage  (pn_r),
    .re     (ram_re),
    .raddr  (ram_raddr),
    .rtable (rd_table),
    .rpage  (rd_page)
  );

  lpbt_slot_state u_slot_state (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rd_idx   (cmp_idx),
    .rd_flags (flags)
  );

  // decision taken in the update cycle
  always_comb begin
    cmd        = '0;
    hit_next   = 1'b0;
    slot_next  = '0;
    used_next  = 1'b0;
    fetch_next = 1'b0;
    wb_next    = 1'b0;
    tag_we     = 1'b0;
    if (state == ST_UPD) begin
      if (found && (op_r == OP_READ || op_r == OP_WRITE || op_r == OP_RELEASE)) begin
        hit_next  = 1'b1;
        slot_next = found_idx;
        used_next = 1'b1;
        cmd.en       = 1'b1;
        cmd.idx      = found_idx;
        cmd.old_rank = found_rank;
        cmd.pin_we   = 1'b1;
        case (op_r)
          OP_READ: begin
            cmd.promote = 1'b1;
            cmd.pin_val = pin_r;
          end
          OP_WRITE: begin
            cmd.promote   = 1'b1;
            cmd.dirty_set = 1'b1;
          end
          default: begin
          end
        endcase
      end else if (!found && op_r == OP_READ && vic_ok) begin
        slot_next  = vic_idx;
        used_next  = 1'b1;
        fetch_next = 1'b1;
        wb_next    = vic_valid && vic_dirty;
        tag_we     = 1'b1;
        cmd.en       = 1'b1;
        cmd.idx      = vic_idx;
        cmd.old_rank = vic_rank;
        cmd.promote  = 1'b1;
        cmd.fill     = 1'b1;
        cmd.pin_we   = 1'b1;
        cmd.pin_val  = pin_r;
      end
    end
  end

  assign slot_wide = {{SLOT_PORT_W{1'b0}}, slot_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      cmp_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_vld <= !cnt[SLOT_W];
          if (cnt == slot_cnt_t'(SLOTS)) begin
            state <= ST_VICT;
          end
        end
        ST_VICT: begin
          cmp_vld <= 1'b0;
          state   <= ST_UPD;
        end
        ST_UPD: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op_r   <= opcode;
        tid_r  <= file_id;
        pn_r   <= page_no;
        pin_r  <= pin;
        cnt    <= '0;
        found  <= 1'b0;
        vic_ok <= 1'b0;
      end
      ST_SCAN: begin
        cnt     <= cnt + 1'b1;
        cmp_idx <= cnt[SLOT_W-1:0];
        if (cmp_vld) begin
          if (!found && flags.valid && rd_table == tid_r && rd_page == pn_r) begin
            found      <= 1'b1;
            found_idx  <= cmp_idx;
            found_rank <= flags.rank;
          end
          if (!flags.pinned && (!vic_ok || flags.rank > vic_rank)) begin
            vic_ok    <= 1'b1;
            vic_idx   <= cmp_idx;
            vic_rank  <= flags.rank;
            vic_valid <= flags.valid;
            vic_dirty <= flags.dirty;
          end
        end
      end
      ST_UPD: begin
        hit              <= hit_next;
        slot             <= slot_wide[SLOT_PORT_W-1:0];
        slot_used        <= used_next;
        fetch_needed     <= fetch_next;
        writeback_needed <= wb_next;
        writeback_table  <= wb_next ? rd_table : '0;
        writeback_page   <= wb_next ? rd_page : '0;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/lpbt_tag_ram.sv
module lpbt_tag_ram
  import lpbt_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  slot_idx_t         waddr,
  input  logic [TID_W-1:0]  wtable,
  input  logic [PAGE_W-1:0] wpage,
  input  logic              re,
  input  slot_idx_t         raddr,
  output logic [TID_W-1:0]  rtable,
  output logic [PAGE_W-1:0] rpage
);

  logic [TID_W-1:0]  mem_table [SLOTS];
  logic [PAGE_W-1:0] mem_page  [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_table[waddr] <= wtable;
      mem_page[waddr]  <= wpage;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rtable <= mem_table[raddr];
      rpage  <= mem_page[raddr];
    end
  end

endmodule

>>> rtl/lpbt_slot_state.sv
module lpbt_slot_state
  import lpbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  slot_cmd_t   cmd,
  input  slot_idx_t   rd_idx,
  output slot_flags_t rd_flags
);

  logic      valid  [SLOTS];
  logic      dirty  [SLOTS];
  logic      pinned [SLOTS];
  slot_idx_t rank   [SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        valid[i]  <= 1'b0;
        dirty[i]  <= 1'b0;
        pinned[i] <= 1'b0;
        rank[i]   <= SLOT_W'(i);
      end
    end else if (cmd.en) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (cmd.promote) begin
          if (SLOT_W'(i) == cmd.idx) begin
            rank[i] <= '0;
          end else if (rank[i] < cmd.old_rank) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end
      end
      if (cmd.fill) begin
        valid[cmd.idx] <= 1'b1;
        dirty[cmd.idx] <= 1'b0;
      end
      if (cmd.dirty_set) begin
        dirty[cmd.idx] <= 1'b1;
      end
      if (cmd.pin_we) begin
        pinned[cmd.idx] <= cmd.pin_val;
      end
    end
  end

  assign rd_flags.valid  = valid[rd_idx];
  assign rd_flags.dirty  = dirty[rd_idx];
  assign rd_flags.pinned = pinned[rd_idx];
  assign rd_flags.rank   = rank[rd_idx];

endmodule

>>> bench/tb_top.sv
module tb_top;
  import lpbt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int POOL_SIZE  = 24;
  localparam int N_RANDOM   = 925;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYC = 25;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TID_W-1:0]  tid;
    logic [PAGE_W-1:0] pn;
    logic              pin;
    logic              drain;
  } page_access_t;

  typedef struct packed {
    logic                   hit;
    logic [SLOT_PORT_W-1:0] slot;
    logic                   slot_used;
    logic                   fetch_needed;
    logic                   wb_needed;
    logic [TID_W-1:0]       wb_table;
    logic [PAGE_W-1:0]      wb_page;
  } access_result_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [OP_W-1:0]        opcode;
  logic [TID_W-1:0]       file_id;
  logic [PAGE_W-1:0]      page_no;
  logic                   pin;
  logic                   done;
  logic                   hit;
  logic [SLOT_PORT_W-1:0] slot;
  logic                   slot_used;
  logic                   fetch_needed;
  logic                   writeback_needed;
  logic [TID_W-1:0]       writeback_table;
  logic [PAGE_W-1:0]      writeback_page;

  lru_page_buffer_tags i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .opcode           (opcode),
    .file_id          (file_id),
    .page_no          (page_no),
    .pin              (pin),
    .done             (done),
    .hit              (hit),
    .slot             (slot),
    .slot_used        (slot_used),
    .fetch_needed     (fetch_needed),
    .writeback_needed (writeback_needed),
    .writeback_table  (writeback_table),
    .writeback_page   (writeback_page)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Shadow copy of the tag store and replacement state
  logic [TID_W-1:0]  sh_tid    [SLOTS];
  logic [PAGE_W-1:0] sh_page   [SLOTS];
  logic              sh_valid  [SLOTS];
  logic              sh_dirty  [SLOTS];
  logic              sh_pinned [SLOTS];
  logic [SLOT_W-1:0] sh_rank   [SLOTS];

  page_access_t   access_q[$];
  access_result_t expected_q[$];
  logic [TID_W-1:0]  pool_tid [POOL_SIZE];
  logic [PAGE_W-1:0] pool_pn  [POOL_SIZE];

  int accept_cnt;
  int fault_cnt;
  int idle_cyc;

  function automatic void promote_slot(int s);
    logic [SLOT_W-1:0] old;
    old = sh_rank[s];
    for (int i = 0; i < SLOTS; i++) begin
      if (sh_rank[i] < old) sh_rank[i] = sh_rank[i] + 1'b1;
    end
    sh_rank[s] = '0;
  endfunction

  function automatic access_result_t predict_access(logic [OP_W-1:0] op,
                                                    logic [TID_W-1:0] tid,
                                                    logic [PAGE_W-1:0] pn,
                                                    logic pin_req);
    access_result_t r;
    int found;
    int victim;
    r = '0;
    found = -1;
    victim = -1;
    if (op == OP_NONE) return r;
    for (int i = 0; i < SLOTS; i++) begin
      if (found < 0 && sh_valid[i] && sh_tid[i] == tid && sh_page[i] == pn) found = i;
    end
    if (found >= 0) begin
      r.hit       = 1'b1;
      r.slot      = found[SLOT_PORT_W-1:0];
      r.slot_used = 1'b1;
      if (op == OP_READ) begin
        promote_slot(found);
        sh_pinned[found] = pin_req;
      end else if (op == OP_WRITE) begin
        promote_slot(found);
        sh_dirty[found]  = 1'b1;
        sh_pinned[found] = 1'b0;
      end else begin
        sh_pinned[found] = 1'b0;
      end
      return r;
    end
    if (op != OP_READ) return r;
    for (int i = 0; i < SLOTS; i++) begin
      if (!sh_pinned[i] && (victim < 0 || sh_rank[i] > sh_rank[victim])) victim = i;
    end
    if (victim < 0) return r;
    r.slot         = victim[SLOT_PORT_W-1:0];
    r.slot_used    = 1'b1;
    r.fetch_needed = 1'b1;
    if (sh_valid[victim] && sh_dirty[victim]) begin
      r.wb_needed = 1'b1;
      r.wb_table  = sh_tid[victim];
      r.wb_page   = sh_page[victim];
    end
    sh_tid[victim]    = tid;
    sh_page[victim]   = pn;
    sh_valid[victim]  = 1'b1;
    sh_dirty[victim]  = 1'b0;
    sh_pinned[victim] = pin_req;
    promote_slot(victim);
    return r;
  endfunction

  function automatic page_access_t pool_access(logic [OP_W-1:0] op, int p, logic pin_req);
    page_access_t a;
    a.op    = op;
    a.tid   = pool_tid[p];
    a.pn    = pool_pn[p];
    a.pin   = pin_req;
    a.drain = 1'b0;
    return a;
  endfunction

  function automatic page_access_t random_access();
    page_access_t a;
    int sel;
    int p;
    sel = $urandom_range(0, 99);
    if (sel < 45)      a.op = OP_READ;
    else if (sel < 70) a.op = OP_WRITE;
    else if (sel < 95) a.op = OP_RELEASE;
    else               a.op = OP_NONE;
    if ($urandom_range(0, 99) < 85) begin
      p = $urandom_range(0, POOL_SIZE - 1);
      a.tid = pool_tid[p];
      a.pn  = pool_pn[p];
    end else begin
      a.tid = TID_W'($urandom());
      a.pn  = $urandom();
    end
    a.pin   = (a.op == OP_READ) ? ($urandom_range(0, 99) < 30) : 1'($urandom_range(0, 1));
    a.drain = ($urandom_range(0, 99) == 0);
    return a;
  endfunction

  // Driver: presents the next pending transaction at the falling edge
  int shown_idx;
  int burst_left;
  int gap_left;

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && accept_cnt != shown_idx) begin
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (accept_cnt < access_q.size() &&
                   (!access_q[accept_cnt].drain ||
                    (start && shown_idx == accept_cnt) ||
                    (expected_q.size() == 0 && !busy))) begin
        start   <= 1'b1;
        opcode  <= access_q[accept_cnt].op;
        file_id <= access_q[accept_cnt].tid;
        page_no <= access_q[accept_cnt].pn;
        pin     <= access_q[accept_cnt].pin;
        shown_idx = accept_cnt;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks results, then records the transaction accepted at this edge
  always @(posedge clk) begin
    access_result_t got;
    access_result_t want;
    if (rst) begin
      idle_cyc <= 0;
    end else begin
      if (done || (start && !busy)) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (done) begin
        got = '{hit, slot, slot_used, fetch_needed, writeback_needed,
                writeback_table, writeback_page};
        if (expected_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= 10) $display("unexpected result, no transaction pending");
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fault_cnt++;
            if (fault_cnt <= 10)
              $display("mismatch: exp hit=%b slot=%0d used=%b fetch=%b wb=%b tid=%0d page=%h",
                       want.hit, want.slot, want.slot_used, want.fetch_needed,
                       want.wb_needed, want.wb_table, want.wb_page,
                       "\n          got hit=%b slot=%0d used=%b fetch=%b wb=%b tid=%0d page=%h",
                       got.hit, got.slot, got.slot_used, got.fetch_needed,
                       got.wb_needed, got.wb_table, got.wb_page);
          end
        end
      end
      if (start && !busy) begin
        expected_q.push_back(predict_access(opcode, file_id, page_no, pin));
        accept_cnt++;
      end
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    page_access_t a;
    start      = 1'b0;
    opcode     = OP_READ;
    file_id    = '0;
    page_no    = '0;
    pin        = 1'b0;
    accept_cnt = 0;
    fault_cnt  = 0;
    shown_idx  = -1;
    burst_left = 1;
    gap_left   = 0;
    rst        = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      sh_tid[i]    = '0;
      sh_page[i]   = '0;
      sh_valid[i]  = 1'b0;
      sh_dirty[i]  = 1'b0;
      sh_pinned[i] = 1'b0;
      sh_rank[i]   = i[SLOT_W-1:0];
    end

    pool_tid[0] = '0;  pool_pn[0] = '0;
    pool_tid[1] = '1;  pool_pn[1] = '1;
    pool_tid[2] = '0;  pool_pn[2] = '1;
    pool_tid[3] = '1;  pool_pn[3] = '0;
    for (int i = 4; i < POOL_SIZE; i++) begin
      pool_tid[i] = TID_W'($urandom());
      pool_pn[i]  = $urandom();
    end
    // near neighbours of existing tags to exercise the compare
    pool_tid[20] = pool_tid[8];
    pool_pn[20]  = pool_pn[8] ^ (32'h1 << $urandom_range(0, 31));
    pool_tid[21] = pool_tid[9] ^ (6'h1 << $urandom_range(0, 5));
    pool_pn[21]  = pool_pn[9];

    // fill every slot pinned, then bypass, write hit/miss, release hit/miss
    for (int i = 0; i < SLOTS; i++) access_q.push_back(pool_access(OP_READ, i, 1'b1));
    access_q.push_back(pool_access(OP_READ, 16, 1'b0));
    access_q.push_back(pool_access(OP_WRITE, 5, 1'b1));
    access_q.push_back(pool_access(OP_WRITE, 16, 1'b0));
    access_q.push_back(pool_access(OP_RELEASE, 17, 1'b1));
    access_q.push_back(pool_access(OP_RELEASE, 3, 1'b0));
    access_q.push_back(pool_access(OP_NONE, 1, 1'b1));
    access_q.push_back(pool_access(OP_READ, 16, 1'b0));
    access_q.push_back(pool_access(OP_READ, 17, 1'b1));
    access_q.push_back(pool_access(OP_READ, 16, 1'b1));
    for (int i = 0; i < N_RANDOM; i++) begin
      a = random_access();
      if (i == 0) a.drain = 1'b1;
      access_q.push_back(a);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (accept_cnt == access_q.size());
    wait (expected_q.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk);
    if (fault_cnt == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
